// ===== hdl/keyed_entry_table_core_defines.svh =====
// Assertion macros shared by the keyed entry table RTL.
`ifndef KEYED_ENTRY_TABLE_CORE_DEFINES_SVH
`define KEYED_ENTRY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ket_pkg.sv =====
// Shared types and constants of the keyed entry table.
`default_nettype none

package ket_pkg;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEFAULT = 16;

    // Field widths of one transaction.
    localparam int KEY_W    = 16;
    localparam int TIME_W   = 16;
    localparam int STATUS_W = 3;

    // Command codes.
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DEL = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_MISSING = 3'd4
    } status_code_t;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         latch;
        logic         idx_clear;
        logic         idx_inc;
        logic         rd_en;
        logic         rd_next;
        logic         wr_en;
        logic         wr_shift;
        logic         count_inc;
        logic         count_dec;
        logic         respond;
        status_code_t code;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_del;
        logic full;
        logic empty;
        logic key_match;
        logic last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/ket_ctrl.sv =====
// Controller state machine that sequences the table scan and compaction.
`default_nettype none

module ket_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ket_pkg::dp_status_t stat,
    output ket_pkg::ctrl_cmd_t     cmd,
    output logic                   busy
);
    import ket_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CHECK    = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CMP = 7'b0001000,
        S_APPEND   = 7'b0010000,
        S_SHIFT_RD = 7'b0100000,
        S_SHIFT_WR = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.is_del && stat.full)
                begin
                    cmd.respond = 1'b1;
                    cmd.code    = ST_FULL;
                    state_next  = S_IDLE;
                end
                else if (stat.empty)
                begin
                    if (stat.is_del)
                    begin
                        cmd.respond = 1'b1;
                        cmd.code    = ST_EMPTY;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
                else
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.key_match)
                begin
                    if (stat.is_del)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        cmd.respond = 1'b1;
                        cmd.code    = ST_DUP;
                        state_next  = S_IDLE;
                    end
                end
                else if (stat.last)
                begin
                    if (stat.is_del)
                    begin
                        cmd.respond = 1'b1;
                        cmd.code    = ST_MISSING;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_APPEND:
            begin
                cmd.wr_en     = 1'b1;
                cmd.count_inc = 1'b1;
                cmd.respond   = 1'b1;
                cmd.code      = ST_OK;
                state_next    = S_IDLE;
            end
            S_SHIFT_RD:
            begin
                if (stat.last)
                begin
                    cmd.count_dec = 1'b1;
                    cmd.respond   = 1'b1;
                    cmd.code      = ST_OK;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/ket_datapath.sv =====
// Datapath of the keyed entry table: entry memory, fill count, index and result registers.
`default_nettype none

module ket_datapath #(
    parameter int TABLE_DEPTH = ket_pkg::TABLE_DEPTH_DEFAULT,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ket_pkg::ctrl_cmd_t           cmd,
    input  wire logic                         opcode,
    input  wire logic [ket_pkg::KEY_W-1:0]    key_id,
    input  wire logic [ket_pkg::TIME_W-1:0]   arrive_time,
    input  wire logic [ket_pkg::TIME_W-1:0]   run_length,
    output ket_pkg::dp_status_t               stat,
    output logic                              done,
    output logic [ket_pkg::STATUS_W-1:0]      status,
    output logic [CW-1:0]                     entry_total
);
    import ket_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Entry memory, one word per slot.
    entry_t mem [TABLE_DEPTH];

    // Latched command transaction.
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] arrival_reg;
    logic [TIME_W-1:0] burst_reg;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    entry_t            rd_data_reg;
    logic              done_reg;
    status_code_t      status_reg;

    logic [CW-1:0]     idx_plus_one;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    entry_t            wr_data;

    // Command latch; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= opcode;
            key_reg     <= key_id;
            arrival_reg <= arrive_time;
            burst_reg   <= run_length;
        end
    end

    // Address and data selection.
    always_comb
    begin
        idx_plus_one = CW'(idx_reg) + CW'(1);
        rd_addr      = cmd.rd_next ? IW'(idx_plus_one) : idx_reg;
        wr_addr      = cmd.wr_shift ? idx_reg : IW'(count_reg);
        if (cmd.wr_shift)
        begin
            wr_data = rd_data_reg;
        end
        else
        begin
            wr_data.key     = key_reg;
            wr_data.arrival = arrival_reg;
            wr_data.burst   = burst_reg;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Index and count updates.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = IW'(idx_plus_one);
        end
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= cmd.respond;
        end
    end

    // Result status register.
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            status_reg <= cmd.code;
        end
    end

    // Status towards the controller.
    always_comb
    begin
        stat.is_del    = (op_reg == OP_DEL);
        stat.full      = (count_reg == CW'(TABLE_DEPTH));
        stat.empty     = (count_reg == '0);
        stat.key_match = (rd_data_reg.key == key_reg);
        stat.last      = (idx_plus_one == count_reg);
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_total = count_reg;

endmodule

`default_nettype wire

// ===== hdl/keyed_entry_table_core.sv =====
// Top level of the keyed entry table: controller, datapath and checks.
//
// A command transaction is taken when start is high and busy is low; busy then
// stays high until the result is produced. The result (status and entry_total)
// is shown for exactly one cycle with done high and must be taken in that
// cycle, since the block cannot hold it. A rejected add to a full table or
// delete from an empty one is answered straight from the check state, and an
// add to an empty table goes from there to the append state. Otherwise the
// controller walks the entry memory through its single registered read port,
// with a read state and a compare state per entry examined, and a delete then
// compacts the table with a read state and a write state per entry moved down.
// A successful command ends in the append state or at the end of compaction,
// and a duplicate or not-found rejection ends in the compare state. busy falls
// in the cycle in which done is high, so a new command may be given then.
`default_nettype none

`include "keyed_entry_table_core_defines.svh"

module keyed_entry_table_core #(
    parameter int TABLE_DEPTH = ket_pkg::TABLE_DEPTH_DEFAULT,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         opcode,
    input  wire logic [ket_pkg::KEY_W-1:0]    key_id,
    input  wire logic [ket_pkg::TIME_W-1:0]   arrive_time,
    input  wire logic [ket_pkg::TIME_W-1:0]   run_length,
    output logic                              done,
    output logic [ket_pkg::STATUS_W-1:0]      status,
    output logic [CW-1:0]                     entry_total
);
    import ket_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // Command sequencing.
    ket_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Storage and comparison.
    ket_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CW          (CW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (opcode),
        .key_id      (key_id),
        .arrive_time (arrive_time),
        .run_length  (run_length),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .entry_total (entry_total)
    );

    // A result only ever appears once the controller has returned to idle.
    `KET_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
    // An accepted transaction always makes the block busy.
    `KET_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not start")
    // The fill count never exceeds the table depth.
    `KET_ASSERT_NOW(a_count_bound, 1'b1, entry_total <= CW'(TABLE_DEPTH), "fill count overflow")
    // A rejected command leaves the entry count unchanged.
    `KET_ASSERT_NOW(a_reject_stable, done && (status != ST_OK), $stable(entry_total), "rejected command changed count")
    // A successful command changes the entry count.
    `KET_ASSERT_NOW(a_ok_changes, done && (status == ST_OK), !$stable(entry_total), "successful command left count unchanged")

endmodule

`default_nettype wire
